// ===== design/wtrm_pkg.sv =====
// Shared types and constants for the windowed transfer rate meter.
// No dependencies; imported by the ring, the divider and the top level.
package wtrm_pkg;

	localparam int DATA_W = 64;
	localparam int TPS_W  = 32;
	localparam int HALF_W = 32;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int DIV_CNT_W = 6;

	localparam logic [APB_AW-1:0] ADDR_TPS  = 3'd0;
	localparam logic [TPS_W-1:0]  TPS_RESET = 32'd1000000;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// One stored sample; packs as timestamp above progress
	typedef struct packed {
		logic [DATA_W-1:0] ts;
		logic [DATA_W-1:0] prog;
	} sample_t;

	// Divider status seen by the sequencer
	typedef struct packed {
		logic done;
		logic sat;
	} div_status_t;

endpackage

// ===== design/wtrm_ring.sv =====
// Sample ring memory: one write port, one registered read port.
// Depends on wtrm_pkg for the sample type.
module wtrm_ring
	import wtrm_pkg::*;
#(
	parameter int DEPTH = 5,
	parameter int AW    = 3
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  sample_t       wdata,
	input  logic [AW-1:0] raddr,
	output sample_t       rdata
);

	sample_t mem_q [DEPTH];
	sample_t rdata_q;

	// Store a sample
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Register the read
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/wtrm_div.sv =====
// Bit-serial 128-by-64 restoring divider, one quotient bit per cycle.
// Flags overflow and zero divisor at start. Depends on wtrm_pkg.
module wtrm_div
	import wtrm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dvd_hi,
	input  logic [DATA_W-1:0] dvd_lo,
	input  logic [DATA_W-1:0] dvsr,
	output logic [DATA_W-1:0] quot,
	output div_status_t       status
);

	logic                 busy_q;
	logic                 done_q;
	logic                 sat_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    lo_q;
	logic [DATA_W-1:0]    quot_q;
	logic [DATA_W-1:0]    dvsr_q;

	logic [DATA_W-1:0] rem_sh;
	logic [DATA_W:0]   diff;
	logic              over;

	// Shared subtractor: shifted remainder minus divisor
	assign rem_sh = {rem_q[DATA_W-2:0], lo_q[DATA_W-1]};
	assign diff   = {rem_q[DATA_W-1], rem_sh} - {1'b0, dvsr_q};
	assign over   = (dvsr == '0) || (dvd_hi >= dvsr);

	// Control: start, count steps, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !over;
			done_q <= over;
			sat_q  <= over;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == '1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: load operands, then shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dvd_hi;
			lo_q   <= dvd_lo;
			dvsr_q <= dvsr;
			quot_q <= over ? '1 : '0;
		end else if (busy_q) begin
			lo_q <= {lo_q[DATA_W-2:0], 1'b0};
			if (!diff[DATA_W]) begin
				rem_q  <= diff[DATA_W-1:0];
				quot_q <= {quot_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				quot_q <= {quot_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign quot        = quot_q;
	assign status.done = done_q;
	assign status.sat  = sat_q;

endmodule

// ===== design/windowed_transfer_rate_meter_top.sv =====
// Windowed transfer rate meter: rate over the last WINDOW samples.
// Add: ready again the next cycle. Query with two or more samples held: 2 ring reads,
// 2 half-width multiplies, 64 divider steps; a saturating rate skips the divider steps,
// and with fewer samples the reads go straight to the result. One item at a time.
// Reset (arst_n, async, active low) empties the ring and loads ticks_per_second.
// Depends on wtrm_pkg, wtrm_ring, wtrm_div.
module windowed_transfer_rate_meter_top
	import wtrm_pkg::*;
#(
	parameter int WINDOW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [127:0]      s_tdata,   // [63:0] progress, [127:64] timestamp
	input  logic              s_tuser,   // [0] action
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       m_tdata,   // [63:0] rate
	output logic              m_tuser,   // [0] saturated
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int IDX_W  = $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(WINDOW - 1);
	localparam logic [FILL_W-1:0] FULL      = FILL_W'(WINDOW);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_RD_NEW = 10'b0000000010,
		ST_RD_OLD = 10'b0000000100,
		ST_DIFF   = 10'b0000001000,
		ST_MUL_LO = 10'b0000010000,
		ST_MUL_HI = 10'b0000100000,
		ST_COMB   = 10'b0001000000,
		ST_START  = 10'b0010000000,
		ST_DIV    = 10'b0100000000,
		ST_OUT    = 10'b1000000000
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    wslot_q;
	logic [FILL_W-1:0]   fill_q;
	logic [TPS_W-1:0]    tps_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_rate_q;
	logic                out_sat_q;

	sample_t             new_q;
	logic [DATA_W-1:0]   dp_q;
	logic [DATA_W-1:0]   dt_q;
	logic [DATA_W-1:0]   p0_q;
	logic [DATA_W-1:0]   p1_q;
	logic [DATA_W-1:0]   dvd_hi_q;
	logic [DATA_W-1:0]   dvd_lo_q;
	logic [DATA_W-1:0]   res_q;
	logic                res_sat_q;

	logic                accept;
	logic                add_req;
	logic                cfg_wr;
	logic [IDX_W-1:0]    newest;
	logic [IDX_W-1:0]    oldest;
	logic [IDX_W-1:0]    raddr;
	sample_t             rdata;
	logic [HALF_W-1:0]   mul_a;
	logic [DATA_W-1:0]   mul_p;
	logic [2*DATA_W-1:0] dvd_sum;
	logic                div_start;
	logic [DATA_W-1:0]   div_quot;
	div_status_t         div_st;
	logic                out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign add_req  = accept && (s_tuser == ACT_ADD);
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr == ADDR_TPS);
	assign out_free = !out_valid_q || m_tready;

	// Ring positions of the newest and oldest held samples
	assign newest = (wslot_q == '0) ? LAST_SLOT : wslot_q - IDX_W'(1);
	assign oldest = (fill_q < FULL) ? '0 : wslot_q;
	assign raddr  = (state_q == ST_RD_OLD) ? oldest : newest;

	wtrm_ring #(
		.DEPTH(WINDOW),
		.AW   (IDX_W)
	) u_ring (
		.clk  (clk),
		.we   (add_req),
		.waddr(wslot_q),
		.wdata(sample_t'(s_tdata)),
		.raddr(raddr),
		.rdata(rdata)
	);

	// One 32x32 multiplier, used for the low then the high half of dp
	assign mul_a   = (state_q == ST_MUL_HI) ? dp_q[DATA_W-1:HALF_W] : dp_q[HALF_W-1:0];
	assign mul_p   = {{HALF_W{1'b0}}, mul_a} * {{(DATA_W-TPS_W){1'b0}}, tps_q};
	assign dvd_sum = {{HALF_W{1'b0}}, p1_q, {HALF_W{1'b0}}} + {{DATA_W{1'b0}}, p0_q};

	assign div_start = (state_q == ST_START);

	wtrm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.dvd_hi(dvd_hi_q),
		.dvd_lo(dvd_lo_q),
		.dvsr  (dt_q),
		.quot  (div_quot),
		.status(div_st)
	);

	// Sequencer, ring pointers, register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wslot_q     <= '0;
			fill_q      <= '0;
			tps_q       <= TPS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				tps_q <= pwdata[TPS_W-1:0];
			end
			// Raise the result when it loads, drop it once taken
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (add_req) begin
						wslot_q <= (wslot_q == LAST_SLOT) ? '0 : wslot_q + IDX_W'(1);
						if (fill_q < FULL) begin
							fill_q <= fill_q + FILL_W'(1);
						end
					end else if (accept) begin
						state_q <= ST_RD_NEW;
					end
				end
				ST_RD_NEW: state_q <= ST_RD_OLD;
				ST_RD_OLD: state_q <= ST_DIFF;
				ST_DIFF: begin
					if (fill_q < FILL_W'(2)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_MUL_LO;
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_COMB;
				ST_COMB:   state_q <= ST_START;
				ST_START:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_RD_OLD: new_q <= rdata;
			ST_DIFF: begin
				dp_q      <= new_q.prog - rdata.prog;
				dt_q      <= new_q.ts - rdata.ts;
				res_q     <= (fill_q == '0) ? '0 : new_q.prog;
				res_sat_q <= 1'b0;
			end
			ST_MUL_LO: p0_q <= mul_p;
			ST_MUL_HI: p1_q <= mul_p;
			ST_COMB: begin
				dvd_hi_q <= dvd_sum[2*DATA_W-1:DATA_W];
				dvd_lo_q <= dvd_sum[DATA_W-1:0];
			end
			ST_DIV: begin
				if (div_st.done) begin
					res_q     <= div_quot;
					res_sat_q <= div_st.sat;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_rate_q <= res_q;
					out_sat_q  <= res_sat_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_rate_q;
	assign m_tuser  = out_sat_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_TPS) ? {{(APB_DW-TPS_W){1'b0}}, tps_q} : '0;

endmodule

// ===== design/wtrm_chk.sv =====
// Port-level checks for the windowed transfer rate meter, bound to the top.
// Depends on the top level's port names.
module wtrm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser,
	input logic        pready
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// A saturated result carries all ones
	a_sat_ones: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 64'hFFFF_FFFF_FFFF_FFFF)
		else $error("saturated rate not all ones");

	// After an add request the block is ready again in the next cycle
	a_add_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> s_tready)
		else $error("not ready after add");

	// A query request keeps the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("ready right after query");

	// The register port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind windowed_transfer_rate_meter_top wtrm_chk u_chk (.*);

// ===== test/tb.sv =====
// Self-checking testbench for windowed_transfer_rate_meter_top.
// Drives add and query requests, predicts each rate in its own model of the
// window ring and checks every result. Depends on wtrm_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
	import wtrm_pkg::*;

	localparam int WIN         = 5;
	localparam int SETTLE_CYC  = 100;
	localparam int HOLDOFF_CYC = 600;
	localparam int RAND_PHASES = 5;
	localparam int RAND_ITEMS  = 90;

	typedef struct packed {
		logic              action;
		logic [DATA_W-1:0] prog;
		logic [DATA_W-1:0] ts;
	} meter_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] rate;
		logic              sat;
	} rate_res_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [127:0]      s_tdata = '0;  // [63:0] progress, [127:64] timestamp
	logic              s_tuser = 1'b0; // [0] action
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [63:0]       m_tdata;        // [63:0] rate
	logic              m_tuser;        // [0] saturated
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	windowed_transfer_rate_meter_top #(.WINDOW(WIN)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Requests waiting for the driver, rates waiting for the monitor
	meter_req_t  pending_reqs[$];
	rate_res_t   expected_rates[$];
	int unsigned error_count = 0;
	int unsigned results_seen = 0;

	// Model of the window: sample ring, slot pointer, fill count, scale
	logic [DATA_W-1:0] win_prog[WIN];
	logic [DATA_W-1:0] win_ts[WIN];
	int unsigned       next_slot = 0;
	int unsigned       held = 0;
	logic [TPS_W-1:0]  model_tps = TPS_RESET;

	// Generator state for well-formed sample sequences
	logic [DATA_W-1:0] seq_prog;
	logic [DATA_W-1:0] seq_ts;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("windowed_transfer_rate_meter_top regression: fail");
		$finish;
	end

	task automatic note_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// Apply one accepted request to the window model; push the rate a query yields
	task automatic advance_meter(input meter_req_t req);
		int unsigned       newest;
		int unsigned       oldest;
		logic [DATA_W-1:0] dp;
		logic [DATA_W-1:0] dt;
		logic [127:0]      product;
		rate_res_t         res;
		if (req.action == ACT_ADD) begin
			win_prog[next_slot] = req.prog;
			win_ts[next_slot]   = req.ts;
			next_slot = (next_slot + 1) % WIN;
			if (held < WIN)
				held++;
			return;
		end
		res = '0;
		newest = (next_slot + WIN - 1) % WIN;
		if (held == 1) begin
			res.rate = win_prog[newest];
		end else if (held > 1) begin
			oldest  = (held < WIN) ? 0 : next_slot;
			dp      = win_prog[newest] - win_prog[oldest];
			dt      = win_ts[newest] - win_ts[oldest];
			product = 128'(dp) * 128'(model_tps);
			// Zero time span or a quotient past 64 bits saturates
			if (dt == '0 || product[127:64] >= dt) begin
				res.rate = '1;
				res.sat  = 1'b1;
			end else begin
				res.rate = 64'(product / 128'(dt));
			end
		end
		expected_rates.push_back(res);
	endtask

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic push_add(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] t);
		meter_req_t req;
		req.action = ACT_ADD;
		req.prog   = p;
		req.ts     = t;
		pending_reqs.push_back(req);
	endtask

	// Query fields are don't-care; fill them with noise
	task automatic push_query();
		meter_req_t req;
		req.action = ACT_QUERY;
		req.prog   = rand64();
		req.ts     = rand64();
		pending_reqs.push_back(req);
	endtask

	// Mostly monotonic sample streams with queries between, plus noise
	task automatic queue_random(input int unsigned count);
		int unsigned n;
		int unsigned pick;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 11);
			case (pick)
				0: begin
					push_add(rand64(), rand64());
					n++;
				end
				1: begin
					push_query();
					n++;
				end
				2: begin
					// repeat the timestamp
					seq_prog = seq_prog + $urandom_range(0, 5000);
					push_add(seq_prog, seq_ts);
					n++;
				end
				3: begin
					// restart the stream anywhere, wrap included
					seq_prog = rand64();
					seq_ts   = rand64();
				end
				4: begin
					// huge progress jump, likely to overflow
					seq_prog = seq_prog + rand64();
					seq_ts   = seq_ts + $urandom_range(1, 50);
					push_add(seq_prog, seq_ts);
					n++;
				end
				default: begin
					seq_ts   = seq_ts + $urandom_range(1, 2_000_000);
					seq_prog = seq_prog + $urandom_range(0, 1 << 22);
					push_add(seq_prog, seq_ts);
					n++;
					if ($urandom_range(0, 1) == 0) begin
						push_query();
						n++;
					end
				end
			endcase
		end
	endtask

	// Hold until every request is taken and every rate is back, then let
	// trailing adds finish inside the block; sample between edges
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || s_tvalid || expected_rates.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_tps(input logic [TPS_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_TPS;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		model_tps = value;
	endtask

	// Driver: bursts of requests with random gaps between them
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	meter_req_t  next_req;
	meter_req_t  cur_req;
	logic        valid_nxt;

	always @(posedge clk) begin
		if (arst_n) begin
			valid_nxt = s_tvalid;
			if (s_tvalid && s_tready) begin
				cur_req.action = s_tuser;
				cur_req.prog   = s_tdata[63:0];
				cur_req.ts     = s_tdata[127:64];
				advance_meter(cur_req);
				valid_nxt = 1'b0;
			end
			// hold the request while it waits for ready
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					next_req  = pending_reqs.pop_front();
					s_tdata  <= {next_req.ts, next_req.prog};
					s_tuser  <= next_req.action;
					valid_nxt = 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
						                                         : $urandom_range(1, 10);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
					end
				end
			end
			s_tvalid <= valid_nxt;
		end
	end

	// Receiver: rotating stall pattern, one long hold-off once traffic runs
	logic [7:0]  ready_pat = 8'hFF;
	int unsigned pat_left = 0;
	int unsigned holdoff_left = 0;
	logic        holdoff_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pat_left == 0) begin
				pat_left  = $urandom_range(32, 200);
				ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
			end else begin
				pat_left--;
			end
			ready_pat = {ready_pat[0], ready_pat[7:1]};
			if (holdoff_left > 0) begin
				holdoff_left--;
			end else if (!holdoff_done && results_seen >= 40) begin
				holdoff_left = HOLDOFF_CYC;
				holdoff_done = 1'b1;
			end
			m_tready <= (holdoff_left == 0) && ready_pat[0];
		end
	end

	// Monitor: compare each accepted rate with the oldest prediction
	rate_res_t want;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_rates.size() == 0) begin
				note_mismatch($sformatf("unexpected result rate=%h sat=%b", m_tdata, m_tuser));
			end else begin
				want = expected_rates.pop_front();
				if (m_tdata !== want.rate)
					note_mismatch($sformatf("rate %h, want %h", m_tdata, want.rate));
				if (m_tuser !== want.sat)
					note_mismatch($sformatf("saturated %b, want %b", m_tuser, want.sat));
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty, single sample, zero span, overflow, wrap, full ring
		write_tps(TPS_RESET);
		push_query();
		push_add(64'd100, 64'd1000);
		push_query();
		push_add(64'd100, 64'd1000);
		push_query();
		push_add(64'd5100, 64'd2000);
		push_query();
		push_add('1, 64'd3000);
		push_query();
		push_add(64'd200, 64'd4000);
		push_query();
		push_add(64'd0, '1);
		push_query();
		push_add(64'd50, 64'd0);
		push_query();
		push_add(64'd50, 64'd10);
		push_add(64'd50, 64'd20);
		push_add(64'd50, 64'd30);
		push_add(64'd50, 64'd40);
		push_add(64'd50, 64'd50);
		push_query();
		push_add('1, '1);
		push_query();
		push_query();
		wait_idle();

		// Random phases under different scale settings, extremes included
		seq_prog = rand64();
		seq_ts   = rand64();
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: write_tps(32'd1);
				1: write_tps('1);
				2: write_tps($urandom);
				3: write_tps($urandom_range(1, 1000));
				default: write_tps(TPS_RESET);
			endcase
			queue_random(RAND_ITEMS);
			wait_idle();
		end

		if (expected_rates.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", expected_rates.size()));

		if (error_count == 0)
			$display("windowed_transfer_rate_meter_top regression: pass");
		else
			$display("windowed_transfer_rate_meter_top regression: fail");
		$finish;
	end

endmodule

// ===== windowed_transfer_rate_meter_top.f =====
design/wtrm_pkg.sv
design/wtrm_ring.sv
design/wtrm_div.sv
design/windowed_transfer_rate_meter_top.sv
design/wtrm_chk.sv
test/tb.sv
